// File: rtl/soa_pkg.sv
// Shared types and constants of the slab object allocator.
package soa_pkg;

    localparam int SLOTS = 64;
    localparam int OBJS  = 16;

    // List node code for the sentinel, and the end marker of a free list
    localparam logic [6:0] SENT = 7'd64;
    localparam logic [4:0] NIL  = 5'd16;
    localparam logic [6:0] ALLOC_WALK_MAX = 7'd65;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_FREE    = 2'd1;
    localparam logic [1:0] OP_RECLAIM = 2'd2;
    localparam logic [1:0] OP_NONE    = 2'd3;

    localparam logic CFG_PER_SLAB  = 1'b0;
    localparam logic CFG_MIN_SLABS = 1'b1;

    localparam logic ST_DONE = 1'b0;
    localparam logic ST_FAIL = 1'b1;

    typedef struct packed {
        logic [1:0] operation;
        logic [9:0] handle;
    } in_word_t;

    typedef struct packed {
        logic        status;
        logic [9:0]  object_handle;
        logic [6:0]  slabs_released;
        logic [6:0]  slabs_in_use;
        logic [10:0] objects_in_use;
    } out_word_t;

    typedef struct packed {
        logic [1:0] op;
        logic [5:0] slot;
        logic [3:0] idx;
    } cmd_t;

    typedef struct packed {
        logic [4:0] fh;
        logic [4:0] uc;
        logic [4:0] cap;
    } slab_ent_t;

endpackage

// File: rtl/soa_front.sv
// Input side: two-word command queue that splits handles into slot and index.
module soa_front import soa_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_word_t s_word,
    output logic     cmd_valid,
    output cmd_t     cmd,
    input  logic     cmd_pop
);

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;

    assign s_ready   = (count_reg != 2'd2);
    assign push      = s_valid && s_ready;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= '{op: s_word.operation, slot: s_word.handle[9:4],
                                   idx: s_word.handle[3:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (cmd_pop) rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, cmd_pop};
        end
    end

endmodule

// File: rtl/soa_engine.sv
// Back end: sequencer over the slab list, slab table and object link memories.
module soa_engine import soa_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_wr_en,
    input  logic      cfg_wr_idx,
    input  logic [6:0] cfg_wr_data,
    input  logic      cmd_valid,
    input  cmd_t      cmd,
    output logic      cmd_pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_word
);

    localparam logic [4:0] S_IDLE       = 5'd0;
    localparam logic [4:0] S_AL_RD      = 5'd1;
    localparam logic [4:0] S_AL_CHK     = 5'd2;
    localparam logic [4:0] S_OPEN       = 5'd3;
    localparam logic [4:0] S_OPEN_FILL  = 5'd4;
    localparam logic [4:0] S_INS_RD     = 5'd5;
    localparam logic [4:0] S_INS_A      = 5'd6;
    localparam logic [4:0] S_INS_B      = 5'd7;
    localparam logic [4:0] S_TK_RD      = 5'd8;
    localparam logic [4:0] S_TK_OBJ     = 5'd9;
    localparam logic [4:0] S_TK_WR      = 5'd10;
    localparam logic [4:0] S_RC_START   = 5'd11;
    localparam logic [4:0] S_RC_RD      = 5'd12;
    localparam logic [4:0] S_RC_CHK     = 5'd13;
    localparam logic [4:0] S_RC_END_RD  = 5'd14;
    localparam logic [4:0] S_RC_END_CHK = 5'd15;
    localparam logic [4:0] S_FR_RD      = 5'd16;
    localparam logic [4:0] S_FR_CHK     = 5'd17;
    localparam logic [4:0] S_FR_WALK    = 5'd18;
    localparam logic [4:0] S_FR_STEP    = 5'd19;
    localparam logic [4:0] S_FR_WR      = 5'd20;
    localparam logic [4:0] S_NX_RD      = 5'd21;
    localparam logic [4:0] S_NX_CHK     = 5'd22;
    localparam logic [4:0] S_OUT        = 5'd23;

    // memories
    logic [6:0] nxt_mem [SLOTS];
    logic [6:0] prv_mem [SLOTS];
    slab_ent_t  slab_mem [SLOTS];
    logic [4:0] obj_mem [SLOTS*OBJS];

    logic       nxt_we, prv_we, slab_we, obj_we;
    logic [5:0] nxt_wa, prv_wa, slab_wa, nxt_ra, prv_ra, slab_ra;
    logic [6:0] nxt_wd, prv_wd, nxt_q, prv_q;
    slab_ent_t  slab_wd, slab_q;
    logic [9:0] obj_wa, obj_ra;
    logic [4:0] obj_wd, obj_q;

    always_ff @(posedge aclk) begin
        if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
        if (prv_we) prv_mem[prv_wa] <= prv_wd;
        if (slab_we) slab_mem[slab_wa] <= slab_wd;
        if (obj_we) obj_mem[obj_wa] <= obj_wd;
        nxt_q  <= nxt_mem[nxt_ra];
        prv_q  <= prv_mem[prv_ra];
        slab_q <= slab_mem[slab_ra];
        obj_q  <= obj_mem[obj_ra];
    end

    logic [4:0]  state_reg, state_next;
    logic [4:0]  per_reg;
    logic [6:0]  min_reg;
    cmd_t        cmd_reg, cmd_next;
    logic [6:0]  fnf_reg, fnf_next, head_reg, head_next, tail_reg, tail_next;
    logic [SLOTS-1:0] free_reg, free_next;
    logic [6:0]  slab_total_reg, slab_total_next;
    logic [10:0] obj_total_reg, obj_total_next;
    logic [6:0]  cur_reg, cur_next, k_reg, k_next, released_reg, released_next;
    logic [6:0]  saved_reg, saved_next, t_reg, t_next, pv_reg, pv_next;
    logic [6:0]  nx_reg, nx_next, ins_s_reg, ins_s_next, ins_t_reg, ins_t_next;
    logic        retry_reg, retry_next, ret_alloc_reg, ret_alloc_next;
    logic        ins_take_reg, ins_take_next, post_reg, post_next;
    logic [4:0]  fh_reg, fh_next, uc_reg, uc_next, cap_reg, cap_next;
    logic [4:0]  walk_reg, walk_next, cnt_reg, cnt_next;
    logic [4:0]  fill_reg, fill_next, n_reg, n_next;
    logic        status_reg, status_next;
    logic [9:0]  handle_reg, handle_next;
    logic        m_valid_reg, m_valid_next;
    out_word_t   m_word_reg, m_word_next;

    logic [4:0]  eff;
    logic [11:0] carved;
    logic [5:0]  free_slot;
    logic        free_any;
    logic [6:0]  pv_w;
    logic [4:0]  fill_inc;
    logic [4:0]  uc_dec;

    assign eff = (per_reg == 5'd0) ? 5'd1 : ((per_reg > NIL) ? NIL : per_reg);
    assign carved = eff * slab_total_reg;
    assign free_any = |free_reg;
    assign fill_inc = fill_reg + 5'd1;
    assign uc_dec = uc_reg - 5'd1;

    always_comb begin
        free_slot = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (free_reg[i]) free_slot = 6'(i);
        end
    end

    always_comb begin
        state_next = state_reg;  cmd_next = cmd_reg;  fnf_next = fnf_reg;
        head_next = head_reg;  tail_next = tail_reg;  free_next = free_reg;
        slab_total_next = slab_total_reg;  obj_total_next = obj_total_reg;
        cur_next = cur_reg;  k_next = k_reg;  released_next = released_reg;
        saved_next = saved_reg;  t_next = t_reg;  pv_next = pv_reg;  nx_next = nx_reg;
        ins_s_next = ins_s_reg;  ins_t_next = ins_t_reg;  retry_next = retry_reg;
        ret_alloc_next = ret_alloc_reg;  ins_take_next = ins_take_reg;  post_next = post_reg;
        fh_next = fh_reg;  uc_next = uc_reg;  cap_next = cap_reg;
        walk_next = walk_reg;  cnt_next = cnt_reg;  fill_next = fill_reg;  n_next = n_reg;
        status_next = status_reg;  handle_next = handle_reg;
        m_valid_next = m_valid_reg && !m_ready;  m_word_next = m_word_reg;
        cmd_pop = 1'b0;
        nxt_we = 1'b0;  prv_we = 1'b0;  slab_we = 1'b0;  obj_we = 1'b0;
        nxt_wa = '0;  prv_wa = '0;  slab_wa = '0;  obj_wa = '0;
        nxt_wd = '0;  prv_wd = '0;  slab_wd = '0;  obj_wd = '0;
        nxt_ra = '0;  prv_ra = '0;  slab_ra = '0;  obj_ra = '0;
        pv_w = '0;

        case (state_reg)
            S_IDLE: begin
                if (cmd_valid) begin
                    cmd_pop = 1'b1;
                    cmd_next = cmd;
                    released_next = '0;
                    status_next = ST_DONE;
                    handle_next = '0;
                    retry_next = 1'b0;
                    k_next = '0;
                    case (cmd.op)
                        OP_ALLOC:   state_next = S_AL_RD;
                        OP_FREE:    state_next = S_FR_RD;
                        OP_RECLAIM: begin
                            ret_alloc_next = 1'b0;
                            state_next = S_RC_START;
                        end
                        default:    state_next = S_OUT;
                    endcase
                end
            end
            // skip full slabs from first_not_full
            S_AL_RD: begin
                if (fnf_reg == SENT) begin
                    state_next = S_OPEN;
                end else if (k_reg == ALLOC_WALK_MAX) begin
                    cur_next = fnf_reg;
                    state_next = S_TK_RD;
                end else begin
                    slab_ra = fnf_reg[5:0];
                    nxt_ra = fnf_reg[5:0];
                    state_next = S_AL_CHK;
                end
            end
            S_AL_CHK: begin
                if (slab_q.fh == NIL) begin
                    fnf_next = nxt_q;
                    k_next = k_reg + 7'd1;
                    state_next = S_AL_RD;
                end else begin
                    cur_next = fnf_reg;
                    state_next = S_TK_RD;
                end
            end
            S_OPEN: begin
                if (free_any) begin
                    free_next[free_slot] = 1'b0;
                    slab_we = 1'b1;
                    slab_wa = free_slot;
                    slab_wd = '{fh: 5'd0, uc: 5'd0, cap: eff};
                    cur_next = {1'b0, free_slot};
                    fill_next = '0;
                    n_next = eff;
                    state_next = S_OPEN_FILL;
                end else if (!retry_reg) begin
                    retry_next = 1'b1;
                    ret_alloc_next = 1'b1;
                    state_next = S_RC_START;
                end else begin
                    status_next = ST_FAIL;
                    state_next = S_OUT;
                end
            end
            // carve objects: one link word a cycle
            S_OPEN_FILL: begin
                obj_we = 1'b1;
                obj_wa = {cur_reg[5:0], fill_reg[3:0]};
                obj_wd = (fill_inc < n_reg) ? fill_inc : NIL;
                fill_next = fill_inc;
                if (fill_inc == n_reg) begin
                    fnf_next = cur_reg;
                    slab_total_next = slab_total_reg + 7'd1;
                    ins_s_next = cur_reg;
                    ins_t_next = SENT;
                    ins_take_next = 1'b1;
                    post_next = 1'b0;
                    state_next = S_INS_RD;
                end
            end
            S_INS_RD: begin
                prv_ra = ins_t_reg[5:0];
                state_next = S_INS_A;
            end
            S_INS_A: begin
                pv_w = (ins_t_reg == SENT) ? tail_reg : prv_q;
                if (pv_w == SENT) begin
                    head_next = ins_s_reg;
                end else begin
                    nxt_we = 1'b1;
                    nxt_wa = pv_w[5:0];
                    nxt_wd = ins_s_reg;
                end
                prv_we = 1'b1;
                prv_wa = ins_s_reg[5:0];
                prv_wd = pv_w;
                state_next = S_INS_B;
            end
            S_INS_B: begin
                nxt_we = 1'b1;
                nxt_wa = ins_s_reg[5:0];
                nxt_wd = ins_t_reg;
                if (ins_t_reg == SENT) begin
                    tail_next = ins_s_reg;
                end else begin
                    prv_we = 1'b1;
                    prv_wa = ins_t_reg[5:0];
                    prv_wd = ins_s_reg;
                end
                if (ins_take_reg) state_next = S_TK_RD;
                else if (post_reg) state_next = S_NX_RD;
                else state_next = S_OUT;
            end
            S_TK_RD: begin
                slab_ra = cur_reg[5:0];
                nxt_ra = cur_reg[5:0];
                state_next = S_TK_OBJ;
            end
            S_TK_OBJ: begin
                if (slab_q.fh == NIL) begin
                    status_next = ST_FAIL;
                    state_next = S_OUT;
                end else begin
                    fh_next = slab_q.fh;
                    uc_next = slab_q.uc;
                    cap_next = slab_q.cap;
                    t_next = nxt_q;
                    obj_ra = {cur_reg[5:0], slab_q.fh[3:0]};
                    state_next = S_TK_WR;
                end
            end
            S_TK_WR: begin
                slab_we = 1'b1;
                slab_wa = cur_reg[5:0];
                slab_wd = '{fh: obj_q, uc: uc_reg + 5'd1, cap: cap_reg};
                obj_total_next = obj_total_reg + 11'd1;
                if (obj_q == NIL) fnf_next = t_reg;
                handle_next = {cur_reg[5:0], fh_reg[3:0]};
                state_next = S_OUT;
            end
            S_RC_START: begin
                saved_next = fnf_reg;
                if (slab_total_reg < min_reg || carved <= {obj_total_reg, 1'b0}) begin
                    state_next = ret_alloc_reg ? S_OPEN : S_OUT;
                end else begin
                    state_next = S_RC_RD;
                end
            end
            // release empty slabs from the tail, each one read and then checked
            S_RC_RD: begin
                if (tail_reg == SENT) begin
                    state_next = S_RC_END_RD;
                end else begin
                    slab_ra = tail_reg[5:0];
                    prv_ra = tail_reg[5:0];
                    state_next = S_RC_CHK;
                end
            end
            S_RC_CHK: begin
                if (slab_q.uc != 5'd0) begin
                    state_next = S_RC_END_RD;
                end else begin
                    released_next = released_reg + 7'd1;
                    if (fnf_reg == tail_reg) fnf_next = prv_q;
                    if (prv_q == SENT) begin
                        head_next = SENT;
                    end else begin
                        nxt_we = 1'b1;
                        nxt_wa = prv_q[5:0];
                        nxt_wd = SENT;
                    end
                    tail_next = prv_q;
                    free_next[tail_reg[5:0]] = 1'b1;
                    slab_total_next = slab_total_reg - 7'd1;
                    state_next = S_RC_RD;
                end
            end
            S_RC_END_RD: begin
                if (fnf_reg != saved_reg && fnf_reg != SENT) begin
                    slab_ra = fnf_reg[5:0];
                    state_next = S_RC_END_CHK;
                end else begin
                    state_next = ret_alloc_reg ? S_OPEN : S_OUT;
                end
            end
            S_RC_END_CHK: begin
                if (slab_q.fh == NIL) fnf_next = SENT;
                state_next = ret_alloc_reg ? S_OPEN : S_OUT;
            end
            S_FR_RD: begin
                if (free_reg[cmd_reg.slot]) begin
                    state_next = S_OUT;
                end else begin
                    slab_ra = cmd_reg.slot;
                    nxt_ra = cmd_reg.slot;
                    prv_ra = cmd_reg.slot;
                    state_next = S_FR_CHK;
                end
            end
            S_FR_CHK: begin
                fh_next = slab_q.fh;
                uc_next = slab_q.uc;
                cap_next = slab_q.cap;
                nx_next = nxt_q;
                pv_next = prv_q;
                walk_next = slab_q.fh;
                cnt_next = '0;
                if ({1'b0, cmd_reg.idx} >= slab_q.cap || slab_q.uc == 5'd0) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_FR_WALK;
                end
            end
            // double free check along the free list
            S_FR_WALK: begin
                if (walk_reg[4] || cnt_reg[4]) begin
                    state_next = S_FR_WR;
                end else if (walk_reg[3:0] == cmd_reg.idx) begin
                    state_next = S_OUT;
                end else begin
                    obj_ra = {cmd_reg.slot, walk_reg[3:0]};
                    state_next = S_FR_STEP;
                end
            end
            S_FR_STEP: begin
                walk_next = obj_q;
                cnt_next = cnt_reg + 5'd1;
                state_next = S_FR_WALK;
            end
            S_FR_WR: begin
                obj_we = 1'b1;
                obj_wa = {cmd_reg.slot, cmd_reg.idx};
                obj_wd = fh_reg;
                slab_we = 1'b1;
                slab_wa = cmd_reg.slot;
                slab_wd = '{fh: {1'b0, cmd_reg.idx}, uc: uc_dec, cap: cap_reg};
                obj_total_next = obj_total_reg - 11'd1;
                ins_s_next = {1'b0, cmd_reg.slot};
                ins_take_next = 1'b0;
                post_next = 1'b0;
                state_next = S_OUT;
                if (fh_reg == NIL || (uc_dec == 5'd0 && !(nx_reg == SENT && 1'b0))) begin
                    if (fh_reg == NIL) begin
                        fnf_next = {1'b0, cmd_reg.slot};
                        ins_t_next = fnf_reg;
                    end else begin
                        post_next = (fnf_reg == {1'b0, cmd_reg.slot});
                        t_next = pv_reg;
                        ins_t_next = SENT;
                    end
                    if (fh_reg != NIL || nx_reg != fnf_reg) begin
                        // unlink the slab, then relink it before the target
                        if (pv_reg == SENT) begin
                            head_next = nx_reg;
                        end else begin
                            nxt_we = 1'b1;
                            nxt_wa = pv_reg[5:0];
                            nxt_wd = nx_reg;
                        end
                        if (nx_reg == SENT) begin
                            tail_next = pv_reg;
                        end else begin
                            prv_we = 1'b1;
                            prv_wa = nx_reg[5:0];
                            prv_wd = pv_reg;
                        end
                        state_next = S_INS_RD;
                    end
                end
            end
            S_NX_RD: begin
                nxt_ra = t_reg[5:0];
                state_next = S_NX_CHK;
            end
            S_NX_CHK: begin
                fnf_next = (t_reg == SENT) ? head_reg : nxt_q;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_word_next = '{status: status_reg, object_handle: handle_reg,
                                    slabs_released: released_reg,
                                    slabs_in_use: slab_total_reg,
                                    objects_in_use: obj_total_reg};
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;  cur_reg <= cur_next;  k_reg <= k_next;
        released_reg <= released_next;  saved_reg <= saved_next;  t_reg <= t_next;
        pv_reg <= pv_next;  nx_reg <= nx_next;  ins_s_reg <= ins_s_next;
        ins_t_reg <= ins_t_next;  retry_reg <= retry_next;  ret_alloc_reg <= ret_alloc_next;
        ins_take_reg <= ins_take_next;  post_reg <= post_next;
        fh_reg <= fh_next;  uc_reg <= uc_next;  cap_reg <= cap_next;
        walk_reg <= walk_next;  cnt_reg <= cnt_next;  fill_reg <= fill_next;
        n_reg <= n_next;  status_reg <= status_next;  handle_reg <= handle_next;
        m_word_reg <= m_word_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            per_reg        <= 5'd16;
            min_reg        <= 7'd10;
            fnf_reg        <= SENT;
            head_reg       <= SENT;
            tail_reg       <= SENT;
            free_reg       <= '1;
            slab_total_reg <= '0;
            obj_total_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            fnf_reg        <= fnf_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            free_reg       <= free_next;
            slab_total_reg <= slab_total_next;
            obj_total_reg  <= obj_total_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_wr_en) begin
                if (cfg_wr_idx == CFG_PER_SLAB) per_reg <= cfg_wr_data[4:0];
                else min_reg <= cfg_wr_data;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

endmodule

// File: rtl/slab_object_allocator_core.sv
// Allocate takes an object from the first non-full slab, skipping full slabs on the way, and
// opens a new slab and carves its objects when none is left. Free walks the slab's free list
// for a double free, then relinks the slab and re-reads first-not-full where needed. Reclaim
// tests the threshold, then inspects slabs from the tail and ends with first-not-full checks.
// One word is worked at a time by the sequencer; a two-word input queue and an output register
// decouple the channels. Reset is synchronous: list, counters and slot map clear at once.
module slab_object_allocator_core import soa_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_idx,
    input  logic [6:0] cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_word_t   s_word,
    output logic       m_valid,
    input  logic       m_ready,
    output out_word_t  m_word
);

    logic cmd_valid, cmd_pop;
    cmd_t cmd;

    soa_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_word    (s_word),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    soa_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_idx  (cfg_wr_idx),
        .cfg_wr_data (cfg_wr_data),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_word      (m_word)
    );

endmodule

// File: rtl/soa_checker.sv
// Port checks for the slab object allocator, bound to the top level.
module soa_checker import soa_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_word
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_word))
        else $error("result word dropped or changed while stalled");

    a_fail_handle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_word.status == ST_FAIL |-> m_word.object_handle == 10'd0)
        else $error("failed allocate carries a handle");

    a_obj_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_word.objects_in_use <= {m_word.slabs_in_use, 4'b0000})
        else $error("more objects in use than slabs can hold");

endmodule

bind slab_object_allocator_core soa_checker u_soa_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_word  (m_word)
);

// File: dv/slab_object_allocator_core_tb.sv
// Testbench of the slab object allocator core: random and directed words against a predictor.
`timescale 1ns / 1ps

module slab_object_allocator_core_tb;
    import soa_pkg::*;

    logic       aclk;
    logic       aresetn;
    logic       cfg_wr_en;
    logic       cfg_wr_idx;
    logic [6:0] cfg_wr_data;
    logic       s_valid;
    logic       s_ready;
    in_word_t   s_word;
    logic       m_valid;
    logic       m_ready;
    out_word_t  m_word;

    slab_object_allocator_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_idx(cfg_wr_idx), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_word(s_word),
        .m_valid(m_valid), .m_ready(m_ready), .m_word(m_word)
    );

    // allocator mirror
    logic [6:0] lnk_next [0:SLOTS];
    logic [6:0] lnk_prev [0:SLOTS];
    logic [6:0] first_open;
    bit         slot_idle [SLOTS];
    int         free_head [SLOTS];
    int         used_cnt [SLOTS];
    int         slab_cap [SLOTS];
    int         obj_link [SLOTS*OBJS];
    int         slab_tally;
    int         obj_tally;
    int         per_slab_reg;
    int         min_slabs_reg;

    out_word_t  expected_words[$];
    int         live_handles[$];
    int         dead_handles[$];
    int         fail_count;
    bit         quiet;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end

    function automatic int eff_per_slab();
        if (per_slab_reg == 0) return 1;
        if (per_slab_reg > OBJS) return OBJS;
        return per_slab_reg;
    endfunction

    function automatic void mirror_reset();
        for (int i = 0; i <= SLOTS; i++) begin
            lnk_next[i] = SENT;
            lnk_prev[i] = SENT;
        end
        for (int i = 0; i < SLOTS; i++) slot_idle[i] = 1'b1;
        first_open    = SENT;
        slab_tally    = 0;
        obj_tally     = 0;
        per_slab_reg  = 16;
        min_slabs_reg = 10;
    endfunction

    function automatic void unlink_slab(int s);
        logic [6:0] nx, pv;
        nx = lnk_next[s];
        pv = lnk_prev[s];
        lnk_next[pv] = nx;
        lnk_prev[nx] = pv;
    endfunction

    function automatic void link_before(int s, int t);
        logic [6:0] pv;
        pv = lnk_prev[t];
        lnk_next[pv] = 7'(s);
        lnk_prev[s]  = pv;
        lnk_next[s]  = 7'(t);
        lnk_prev[t]  = 7'(s);
    endfunction

    function automatic int reclaim_tail();
        int         released;
        logic [6:0] saved, pos;
        released = 0;
        saved    = first_open;
        if (slab_tally < min_slabs_reg || eff_per_slab() * slab_tally <= obj_tally * 2)
            return 0;
        while (lnk_prev[SENT] != SENT) begin
            pos = lnk_prev[SENT];
            if (used_cnt[pos] != 0) break;
            released++;
            if (first_open == pos) first_open = lnk_prev[pos];
            unlink_slab(pos);
            slot_idle[pos] = 1'b1;
            slab_tally--;
        end
        if (first_open != saved && first_open != SENT && free_head[first_open] == NIL)
            first_open = SENT;
        return released;
    endfunction

    function automatic int open_slab();
        int s, n;
        n = eff_per_slab();
        for (s = 0; s < SLOTS; s++)
            if (slot_idle[s]) break;
        if (s >= SLOTS) return SENT;
        slot_idle[s] = 1'b0;
        slab_cap[s]  = n;
        used_cnt[s]  = 0;
        free_head[s] = 0;
        for (int i = 0; i < n; i++)
            obj_link[s*OBJS + i] = (i + 1 < n) ? i + 1 : NIL;
        link_before(s, SENT);
        first_open = 7'(s);
        slab_tally++;
        return s;
    endfunction

    function automatic bit release_object(int h);
        int         slot, idx, o;
        bit         was_full;
        logic [6:0] t;
        slot = h / OBJS;
        idx  = h % OBJS;
        if (slot_idle[slot] || idx >= slab_cap[slot] || used_cnt[slot] == 0) return 0;
        o = free_head[slot];
        for (int k = 0; k < OBJS && o < OBJS; k++) begin
            if (o == idx) return 0;
            o = obj_link[slot*OBJS + o];
        end
        was_full = (free_head[slot] == NIL);
        obj_link[slot*OBJS + idx] = free_head[slot];
        free_head[slot] = idx;
        used_cnt[slot]--;
        obj_tally--;
        if (was_full) begin
            t = first_open;
            first_open = 7'(slot);
            if (lnk_next[slot] != t) begin
                unlink_slab(slot);
                link_before(slot, t);
            end
        end else if (used_cnt[slot] == 0) begin
            t = lnk_prev[first_open];
            unlink_slab(slot);
            link_before(slot, SENT);
            if (first_open == slot) first_open = lnk_next[t];
        end
        return 1;
    endfunction

    // Works out the result of one accepted word and queues it
    function automatic void predict_allocator(in_word_t w);
        out_word_t r;
        int        s, o;
        r = '0;
        r.status = ST_DONE;
        if (w.operation == OP_ALLOC) begin
            for (int k = 0; k <= SLOTS && first_open != SENT && free_head[first_open] == NIL;
                 k++)
                first_open = lnk_next[first_open];
            if (first_open == SENT) begin
                s = open_slab();
                if (s == SENT) begin
                    r.slabs_released = 7'(reclaim_tail());
                    s = open_slab();
                end
            end else begin
                s = first_open;
            end
            if (s == SENT || free_head[s] >= OBJS) begin
                r.status = ST_FAIL;
            end else begin
                o = free_head[s];
                used_cnt[s]++;
                free_head[s] = obj_link[s*OBJS + o];
                obj_tally++;
                if (free_head[s] == NIL) first_open = lnk_next[s];
                r.object_handle = 10'(s*OBJS + o);
                live_handles.push_back(s*OBJS + o);
            end
        end else if (w.operation == OP_FREE) begin
            if (release_object(w.handle)) begin
                foreach (live_handles[i])
                    if (live_handles[i] == w.handle) begin
                        live_handles.delete(i);
                        break;
                    end
                dead_handles.push_back(w.handle);
                if (dead_handles.size() > 32) void'(dead_handles.pop_front());
            end
        end else if (w.operation == OP_RECLAIM) begin
            r.slabs_released = 7'(reclaim_tail());
        end
        r.slabs_in_use   = 7'(slab_tally);
        r.objects_in_use = 11'(obj_tally);
        expected_words.push_back(r);
    endfunction

    task automatic idle_burst();
        if (!quiet && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 7)) @(negedge aclk);
    endtask

    task automatic send_word(logic [1:0] op, logic [9:0] h);
        in_word_t w;
        w.operation = op;
        w.handle    = h;
        idle_burst();
        @(negedge aclk);
        s_valid <= 1'b1;
        s_word  <= w;
        do @(posedge aclk); while (!s_ready);
        predict_allocator(w);
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // Register writes only once the block has gone quiet
    task automatic write_reg(logic idx, logic [6:0] val);
        wait (expected_words.size() == 0);
        repeat (10) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_idx  <= idx;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_PER_SLAB) per_slab_reg = val & 7'h1f;
        else min_slabs_reg = val;
    endtask

    task automatic free_some_live();
        int i, h;
        i = $urandom_range(0, live_handles.size() - 1);
        h = live_handles[i];
        send_word(OP_FREE, 10'(h));
    endtask

    task automatic test_directed();
        send_word(OP_ALLOC, 10'h3ff);
        send_word(OP_ALLOC, 10'h000);
        send_word(OP_FREE, 10'h3ff);
        send_word(OP_FREE, 10'h000);
        send_word(OP_FREE, 10'h000);    // double free
        send_word(OP_FREE, 10'h010);    // slot never opened
        send_word(OP_NONE, 10'h2aa);
        send_word(OP_NONE, 10'h155);
        send_word(OP_RECLAIM, 10'h000);
        send_word(OP_FREE, 10'h001);
        send_word(OP_RECLAIM, 10'h3ff);
    endtask

    // One object per slab: fill every slot, hit allocation failure, then drain
    task automatic test_slot_exhaustion();
        write_reg(CFG_PER_SLAB, 7'd1);
        write_reg(CFG_MIN_SLABS, 7'd0);
        while (live_handles.size() > 0) free_some_live();
        send_word(OP_RECLAIM, 10'h000);
        repeat (SLOTS + 2) send_word(OP_ALLOC, 10'h000);
        send_word(OP_FREE, 10'h00f);    // index beyond capacity
        repeat (40) free_some_live();
        send_word(OP_ALLOC, 10'h000);   // allocate into a freed slab
        send_word(OP_RECLAIM, 10'h000);
        while (live_handles.size() > 0) free_some_live();
        send_word(OP_RECLAIM, 10'h000);
    endtask

    task automatic test_random_mix(int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (live_handles.size() > 150 && pick < 55) pick += 30;
            if (pick < 55 || live_handles.size() == 0 && pick < 85)
                send_word(OP_ALLOC, 10'($urandom));
            else if (pick < 85)
                free_some_live();
            else if (pick < 90)
                send_word(OP_FREE, 10'($urandom_range(0, 1023)));
            else if (pick < 93 && dead_handles.size() > 0)
                send_word(OP_FREE,
                          10'(dead_handles[$urandom_range(0, dead_handles.size() - 1)]));
            else if (pick < 99)
                send_word(OP_RECLAIM, 10'($urandom));
            else
                send_word(OP_NONE, 10'($urandom));
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_idx  = CFG_PER_SLAB;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_word      = '0;
        fail_count  = 0;
        quiet       = 1'b0;
        mirror_reset();
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_slot_exhaustion();
        write_reg(CFG_PER_SLAB, 7'd5);
        write_reg(CFG_MIN_SLABS, 7'd2);
        test_random_mix(130);
        write_reg(CFG_PER_SLAB, 7'd31);
        write_reg(CFG_MIN_SLABS, 7'd64);
        test_random_mix(130);
        write_reg(CFG_PER_SLAB, 7'd0);
        write_reg(CFG_MIN_SLABS, 7'd0);
        test_random_mix(100);
        write_reg(CFG_PER_SLAB, 7'd16);
        write_reg(CFG_MIN_SLABS, 7'd127);
        test_random_mix(80);
        write_reg(CFG_PER_SLAB, 7'd3);
        write_reg(CFG_MIN_SLABS, 7'd1);
        quiet = 1'b1;
        test_random_mix(90);

        wait (expected_words.size() == 0);
        repeat (200) @(posedge aclk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Result side back-pressure
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!quiet && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 7) - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                $error("result word with none expected: %h", m_word);
                fail_count++;
            end else begin
                want = expected_words.pop_front();
                if (m_word.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_word.status);
                    fail_count++;
                end
                if (m_word.object_handle !== want.object_handle) begin
                    $error("object_handle: expected %0d, got %0d",
                           want.object_handle, m_word.object_handle);
                    fail_count++;
                end
                if (m_word.slabs_released !== want.slabs_released) begin
                    $error("slabs_released: expected %0d, got %0d",
                           want.slabs_released, m_word.slabs_released);
                    fail_count++;
                end
                if (m_word.slabs_in_use !== want.slabs_in_use) begin
                    $error("slabs_in_use: expected %0d, got %0d",
                           want.slabs_in_use, m_word.slabs_in_use);
                    fail_count++;
                end
                if (m_word.objects_in_use !== want.objects_in_use) begin
                    $error("objects_in_use: expected %0d, got %0d",
                           want.objects_in_use, m_word.objects_in_use);
                    fail_count++;
                end
            end
        end
    end

endmodule
